FILE: src/mp2a_pkg.sv
// Shared constants, register codes and types for the max-pool-with-argmax core.
package mp2a_pkg;

   localparam int DEF_MAX_HEIGHT  = 64;
   localparam int DEF_MAX_WIDTH   = 64;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int CSR_ADDR_BITS = 5;

   localparam logic [6:0]  RST_IN_HEIGHT     = 7'd64;
   localparam logic [6:0]  RST_IN_WIDTH      = 7'd64;
   localparam logic [15:0] RST_KERNEL_EXTENT = 16'd514;
   localparam logic [7:0]  RST_ROW_STEPS     = 8'd17;
   localparam logic [7:0]  RST_COL_STEPS     = 8'd17;
   localparam logic [3:0]  RST_PAD_TOP       = 4'd0;
   localparam logic [3:0]  RST_PAD_LEFT      = 4'd0;
   localparam logic        RST_COLUMN_MAJOR  = 1'b0;

   typedef enum logic [2:0] {
      REG_IN_HEIGHT     = 3'd0,
      REG_IN_WIDTH      = 3'd1,
      REG_KERNEL_EXTENT = 3'd2,
      REG_ROW_STEPS     = 3'd3,
      REG_COL_STEPS     = 3'd4,
      REG_PAD_TOP       = 3'd5,
      REG_PAD_LEFT      = 3'd6,
      REG_COLUMN_MAJOR  = 3'd7
   } csr_reg_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_POOL  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPLY
   } state_type;

endpackage

FILE: src/max_pool_2d_with_argmax_core.sv
// Max pooling with argmax over one stored feature-map plane.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start high and
//    busy low. req_cmd selects a sample write (req_pix_row, req_pix_col,
//    req_pix_value) or a pool of output position (req_out_row, req_out_col).
//  - A write completes at its accept edge, gives no result and leaves busy low,
//    so writes can follow back to back.
//  - A pool raises busy and walks the kernel window one tap per cycle through
//    the single read port of the plane memory; the compare unit works on each
//    tap in the cycle after its read. Each window row inside the plane takes
//    one step per column tap, each row outside it is skipped as a whole, and
//    after the last row the walk closes and the reply state follows.
//  - The result shows on rsp_max_value and rsp_arg_index for exactly one cycle
//    with rsp_valid high, while busy is still high. The receiver cannot stall.
//  - Registers sit on the APB-style port at byte address 4*index; write them
//    only while busy is low.
//  - Reset restores the register defaults and returns the sequencer to idle.
//    Plane contents are not cleared and must be written before pooling.
module max_pool_2d_with_argmax_core #(
   parameter int MAX_HEIGHT  = mp2a_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH   = mp2a_pkg::DEF_MAX_WIDTH,
   parameter int SAMPLE_BITS = mp2a_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [5:0]                          req_pix_row,
   input  logic [5:0]                          req_pix_col,
   input  logic signed [15:0]                  req_pix_value,
   input  logic [5:0]                          req_out_row,
   input  logic [5:0]                          req_out_col,
   output logic                                rsp_valid,
   output logic signed [15:0]                  rsp_max_value,
   output logic [11:0]                         rsp_arg_index,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mp2a_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import mp2a_pkg::*;

   localparam int DEPTH     = MAX_HEIGHT * MAX_WIDTH;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [6:0]  in_height_ff;
   logic [6:0]  in_width_ff;
   logic [15:0] kernel_extent_ff;
   logic [7:0]  row_steps_ff;
   logic [7:0]  col_steps_ff;
   logic [3:0]  pad_top_ff;
   logic [3:0]  pad_left_ff;
   logic        column_major_ff;

   state_type                 state_ff, state_in;
   logic [8:0]                m_ff, m_in;
   logic [8:0]                n_ff, n_in;
   logic signed [11:0]        r0_ff, r0_in;
   logic signed [11:0]        c0_ff, c0_in;
   logic                      tap_vld_ff, tap_vld_in;
   logic [11:0]               tap_idx_ff, tap_idx_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in;
   logic [11:0]               best_idx_ff, best_idx_in;

   logic signed [SAMPLE_BITS-1:0] plane_mem [DEPTH];

   logic                 csr_wr;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] tap_addr;
   logic [6:0]           h_eff, w_eff;
   logic [7:0]           kh, kw;
   logic [3:0]           dr, dc;
   logic signed [11:0]   pool_r0, pool_c0;
   logic signed [11:0]   r_cur, c_cur;
   logic                 row_ok, col_ok;
   logic [6:0]           r7, c7, mul_a, mul_b, add_b;
   logic [13:0]          idx_full;
   logic [8:0]           n_next;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff     <= RST_IN_HEIGHT;
         in_width_ff      <= RST_IN_WIDTH;
         kernel_extent_ff <= RST_KERNEL_EXTENT;
         row_steps_ff     <= RST_ROW_STEPS;
         col_steps_ff     <= RST_COL_STEPS;
         pad_top_ff       <= RST_PAD_TOP;
         pad_left_ff      <= RST_PAD_LEFT;
         column_major_ff  <= RST_COLUMN_MAJOR;
      end else if (csr_wr) begin
         case (csr_reg_type'(paddr[4:2]))
            REG_IN_HEIGHT:     in_height_ff     <= pwdata[6:0];
            REG_IN_WIDTH:      in_width_ff      <= pwdata[6:0];
            REG_KERNEL_EXTENT: kernel_extent_ff <= pwdata[15:0];
            REG_ROW_STEPS:     row_steps_ff     <= pwdata[7:0];
            REG_COL_STEPS:     col_steps_ff     <= pwdata[7:0];
            REG_PAD_TOP:       pad_top_ff       <= pwdata[3:0];
            REG_PAD_LEFT:      pad_left_ff      <= pwdata[3:0];
            REG_COLUMN_MAJOR:  column_major_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(paddr[4:2]))
         REG_IN_HEIGHT:     prdata = 32'(in_height_ff);
         REG_IN_WIDTH:      prdata = 32'(in_width_ff);
         REG_KERNEL_EXTENT: prdata = 32'(kernel_extent_ff);
         REG_ROW_STEPS:     prdata = 32'(row_steps_ff);
         REG_COL_STEPS:     prdata = 32'(col_steps_ff);
         REG_PAD_TOP:       prdata = 32'(pad_top_ff);
         REG_PAD_LEFT:      prdata = 32'(pad_left_ff);
         REG_COLUMN_MAJOR:  prdata = 32'(column_major_ff);
         default:           prdata = '0;
      endcase
   end

   // window geometry
   assign h_eff = (int'(in_height_ff) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : in_height_ff;
   assign w_eff = (int'(in_width_ff) > MAX_WIDTH) ? 7'(MAX_WIDTH) : in_width_ff;
   assign kh    = kernel_extent_ff[7:0];
   assign kw    = kernel_extent_ff[15:8];
   assign dr    = (row_steps_ff[7:4] == 4'd0) ? 4'd1 : row_steps_ff[7:4];
   assign dc    = (col_steps_ff[7:4] == 4'd0) ? 4'd1 : col_steps_ff[7:4];

   assign pool_r0 = $signed(12'(req_out_row) * 12'(row_steps_ff[3:0]) - 12'(pad_top_ff));
   assign pool_c0 = $signed(12'(req_out_col) * 12'(col_steps_ff[3:0]) - 12'(pad_left_ff));

   assign r_cur  = r0_ff + $signed({3'b000, m_ff});
   assign c_cur  = c0_ff + $signed({3'b000, n_ff});
   assign row_ok = !r_cur[11] && (r_cur[10:0] < {4'b0000, h_eff});
   assign col_ok = !c_cur[11] && (c_cur[10:0] < {4'b0000, w_eff});
   assign r7     = r_cur[6:0];
   assign c7     = c_cur[6:0];
   assign n_next = n_ff + {5'b00000, dc};

   assign tap_addr = ADDR_BITS'(int'(r7) * MAX_WIDTH + int'(c7));

   assign mul_a    = column_major_ff ? c7 : r7;
   assign mul_b    = column_major_ff ? h_eff : w_eff;
   assign add_b    = column_major_ff ? r7 : c7;
   assign idx_full = 14'(mul_a) * 14'(mul_b) + 14'(add_b);

   // sample store
   assign busy    = (state_ff != ST_IDLE);
   assign wr_en   = start && !busy && (req_cmd == CMD_WRITE)
                    && (int'(req_pix_row) < MAX_HEIGHT) && (int'(req_pix_col) < MAX_WIDTH);
   assign wr_addr = ADDR_BITS'(int'(req_pix_row) * MAX_WIDTH + int'(req_pix_col));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         plane_mem[wr_addr] <= SAMPLE_BITS'(req_pix_value);
      end
      if (rd_en) begin
         rd_data_ff <= plane_mem[tap_addr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tap_vld_ff <= tap_vld_in;
      end
      m_ff        <= m_in;
      n_ff        <= n_in;
      r0_ff       <= r0_in;
      c0_ff       <= c0_in;
      tap_idx_ff  <= tap_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      r0_in       = r0_ff;
      c0_in       = c0_ff;
      tap_vld_in  = 1'b0;
      tap_idx_in  = tap_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      rd_en       = 1'b0;

      if (tap_vld_ff && (rd_data_ff > best_ff)) begin
         best_in     = rd_data_ff;
         best_idx_in = tap_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start && (req_cmd == CMD_POOL)) begin
               state_in    = ST_WALK;
               m_in        = '0;
               n_in        = '0;
               r0_in       = pool_r0;
               c0_in       = pool_c0;
               best_in     = MOST_NEG;
               best_idx_in = '0;
            end
         end
         ST_WALK: begin
            if (m_ff >= {1'b0, kh}) begin
               state_in = ST_REPLY;
            end else if (!row_ok) begin
               m_in = m_ff + {5'b00000, dr};
               n_in = '0;
            end else begin
               if (n_ff < {1'b0, kw}) begin
                  tap_vld_in = col_ok;
                  rd_en      = col_ok;
                  tap_idx_in = idx_full[11:0];
               end
               if (n_next >= {1'b0, kw}) begin
                  m_in = m_ff + {5'b00000, dr};
                  n_in = '0;
               end else begin
                  n_in = n_next;
               end
            end
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = (state_ff == ST_REPLY);
   assign rsp_max_value = 16'(best_ff);
   assign rsp_arg_index = best_idx_ff;

`ifndef ASSERT_OFF
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_pool_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_POOL)) |=> busy)
      else $error("pool transaction did not raise busy");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_WRITE)) |=> !busy)
      else $error("write transaction raised busy");

   a_tap_in_walk: assert property (@(posedge clock) disable iff (reset)
      tap_vld_ff |-> ((state_ff == ST_WALK) || (state_ff == ST_REPLY)))
      else $error("tap compare outside a window walk");
`endif

endmodule
